[hw/rtl/lossy_event_ring_reader_macros.svh]
// Assertion helpers for the trace ring.
`ifndef LOSSY_EVENT_RING_READER_MACROS_SVH
`define LOSSY_EVENT_RING_READER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define LERR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define LERR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define LERR_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lerr_pkg.sv]
package lerr_pkg;

  localparam int RING_RECORDS = 256;
  localparam int MAX_PER_READ = 64;
  localparam int RING_AW      = $clog2(RING_RECORDS);
  localparam int PEND_W       = RING_AW + 1;
  localparam int CNT_W        = 7;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QAW          = $clog2(QUEUE_DEPTH);
  localparam int QCW          = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] in_ticks;
    logic [31:0] in_seq;
    logic [31:0] in_kind;
    logic [31:0] in_context;
    logic [31:0] in_value;
    logic [31:0] in_previous;
    logic [31:0] reader_position;
    logic [6:0]  max_count;
  } lerr_item_t;

  typedef struct packed {
    logic [31:0] out_ticks;
    logic [31:0] out_seq;
    logic [31:0] out_kind;
    logic [31:0] out_context;
    logic [31:0] out_value;
    logic [31:0] out_previous;
    logic        record_valid;
    logic [31:0] lost_count;
    logic [31:0] next_position;
    logic        last;
  } lerr_result_t;

  typedef struct packed {
    logic [31:0] ticks;
    logic [31:0] seq;
    logic [31:0] kind;
    logic [31:0] context_w;
    logic [31:0] value;
    logic [31:0] previous;
  } lerr_rec_t;

  // One classified command, front to back.
  typedef struct packed {
    logic             is_write;
    lerr_rec_t        rec;
    logic             empty;
    logic [31:0]      start_pos;  // write count for writes, first position for reads
    logic [CNT_W-1:0] count;
    logic [31:0]      lost;
    logic [31:0]      reader;
  } lerr_cmd_t;

  typedef struct packed {
    logic      push;
    lerr_cmd_t cmd;
  } lerr_push_t;

endpackage

[hw/rtl/lerr_front.sv]
module lerr_front import lerr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  lerr_item_t item,
  input  logic       q_full,
  output logic       busy,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  output lerr_push_t push_out
);

  logic              usable;
  logic [31:0]       wcount;
  logic              accept;
  logic [31:0]       span;
  logic              over;
  logic [PEND_W-1:0] pending;
  logic [CNT_W-1:0]  limit;
  logic [31:0]       cnt32;
  logic [31:0]       lost;

  assign busy      = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      usable <= 1'b0;
      wcount <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        usable <= cfg_data;
      end
      if (accept && item.op == OP_WRITE) begin
        wcount <= wcount + 32'd1;
      end
    end
  end

  // Distance from reader to writer; anything past the ring size was overwritten.
  always_comb begin
    span  = wcount - item.reader_position;
    over  = span > 32'(RING_RECORDS);
    lost  = (usable && over) ? (span - 32'(RING_RECORDS)) : '0;
    if (!usable) begin
      pending = '0;
    end else if (over) begin
      pending = PEND_W'(RING_RECORDS);
    end else begin
      pending = span[PEND_W-1:0];
    end
    limit = (32'(item.max_count) > 32'(MAX_PER_READ)) ? CNT_W'(MAX_PER_READ)
                                                        : item.max_count;
    cnt32 = (32'(pending) < 32'(limit)) ? 32'(pending) : 32'(limit);
  end

  always_comb begin
    push_out.push               = accept;
    push_out.cmd.is_write       = (item.op == OP_WRITE);
    push_out.cmd.rec.ticks      = item.in_ticks;
    push_out.cmd.rec.seq        = item.in_seq;
    push_out.cmd.rec.kind       = item.in_kind;
    push_out.cmd.rec.context_w  = item.in_context;
    push_out.cmd.rec.value      = item.in_value;
    push_out.cmd.rec.previous   = item.in_previous;
    push_out.cmd.count          = cnt32[CNT_W-1:0];
    push_out.cmd.empty          = (cnt32 == 32'd0);
    push_out.cmd.lost           = lost;
    push_out.cmd.reader         = item.reader_position;
    push_out.cmd.start_pos      = (item.op == OP_WRITE) ? wcount
                                                        : (wcount - 32'(pending));
  end

endmodule

[hw/rtl/lerr_queue.sv]
module lerr_queue import lerr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  lerr_push_t push_in,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output lerr_cmd_t  head
);

  lerr_cmd_t        slots [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == QCW'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push_in.push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_in.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + QCW'(1);
        2'b01:   fill <= fill - QCW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/lerr_back.sv]
module lerr_back import lerr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_empty,
  input  lerr_cmd_t    head,
  output logic         pop,
  output logic         strobe,
  output lerr_result_t result
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_STREAM = 2'b10
  } lerr_state_t;

  lerr_rec_t        ring [RING_RECORDS];
  lerr_rec_t        rd_data;

  lerr_state_t      state, state_next;
  logic [31:0]      pos, pos_next;
  logic [CNT_W-1:0] rem, rem_next;
  logic [31:0]      cur_lost, cur_lost_next;

  logic             out_strobe, out_strobe_next;
  logic             out_rv, out_rv_next;
  logic [31:0]      out_lost, out_lost_next;
  logic [31:0]      out_next, out_next_next;
  logic             out_last, out_last_next;

  logic             mem_we;
  logic             mem_re;

  assign pop    = (state == S_IDLE) && !q_empty;
  assign mem_we = pop && head.is_write;
  assign mem_re = (state == S_STREAM);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[head.start_pos[RING_AW-1:0]] <= head.rec;
    end
    if (mem_re) begin
      rd_data <= ring[pos[RING_AW-1:0]];
    end
  end

  always_comb begin
    state_next      = state;
    pos_next        = pos;
    rem_next        = rem;
    cur_lost_next   = cur_lost;
    out_strobe_next = 1'b0;
    out_rv_next     = out_rv;
    out_lost_next   = out_lost;
    out_next_next   = out_next;
    out_last_next   = out_last;
    case (state)
      S_IDLE: begin
        if (pop && !head.is_write) begin
          if (head.empty) begin
            out_strobe_next = 1'b1;
            out_rv_next     = 1'b0;
            out_lost_next   = head.lost;
            out_next_next   = head.reader;
            out_last_next   = 1'b1;
          end else begin
            pos_next      = head.start_pos;
            rem_next      = head.count;
            cur_lost_next = head.lost;
            state_next    = S_STREAM;
          end
        end
      end
      S_STREAM: begin
        out_strobe_next = 1'b1;
        out_rv_next     = 1'b1;
        out_lost_next   = cur_lost;
        out_next_next   = pos + 32'd1;
        out_last_next   = (rem == CNT_W'(1));
        pos_next        = pos + 32'd1;
        rem_next        = rem - CNT_W'(1);
        if (rem == CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      out_strobe <= out_strobe_next;
    end
    pos      <= pos_next;
    rem      <= rem_next;
    cur_lost <= cur_lost_next;
    out_rv   <= out_rv_next;
    out_lost <= out_lost_next;
    out_next <= out_next_next;
    out_last <= out_last_next;
  end

  assign strobe = out_strobe;

  always_comb begin
    result.out_ticks     = out_rv ? rd_data.ticks     : '0;
    result.out_seq       = out_rv ? rd_data.seq       : '0;
    result.out_kind      = out_rv ? rd_data.kind      : '0;
    result.out_context   = out_rv ? rd_data.context_w : '0;
    result.out_value     = out_rv ? rd_data.value     : '0;
    result.out_previous  = out_rv ? rd_data.previous  : '0;
    result.record_valid  = out_rv;
    result.lost_count    = out_lost;
    result.next_position = out_next;
    result.last          = out_last;
  end

endmodule

[hw/rtl/lossy_event_ring_reader.sv]
// Overwriting trace ring of 256 six-word records with free-running cursors.
// An item is taken when start is high and busy is low; busy rises only when
// the two-entry command queue between the front and the ring side is full.
// A write is stored when the ring side picks it up and returns nothing. A read
// returns N records, one per cycle, set by the single read port of the record
// memory; an empty read returns one result. A record result passes through the
// S_STREAM state and the registered memory read before it appears; an empty-read
// result appears in the cycle after the ring side picks the read up. Each is
// shown for exactly one cycle with strobe high and cannot be held off by the
// receiver. ring_usable is written through the cfg channel, which is always
// ready; write it only while no read is in flight. No clearing pass runs after
// reset.
module lossy_event_ring_reader import lerr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  lerr_item_t   item,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data,
  output logic         strobe,
  output lerr_result_t result
);

  lerr_push_t push_bus;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  lerr_cmd_t  q_head;

  lerr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .q_full   (q_full),
    .busy     (busy),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .push_out (push_bus)
  );

  lerr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push_in(push_bus),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .head   (q_head)
  );

  lerr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .head   (q_head),
    .pop    (q_pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

[hw/rtl/lerr_checker.sv]
`include "lossy_event_ring_reader_macros.svh"

module lerr_checker import lerr_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         strobe,
  input lerr_result_t result
);

  `LERR_ASSERT_ALWAYS(a_quiet_after_reset, rst, !strobe, "strobe right after reset")

  `LERR_ASSERT_IMPL(a_empty_is_last, strobe && !result.record_valid, result.last, "empty read not last")

  `LERR_ASSERT_IMPL(a_empty_zero, strobe && !result.record_valid, result.out_ticks == 32'd0 && result.out_seq == 32'd0 && result.out_previous == 32'd0, "empty read carries data")

  `LERR_ASSERT_NEXT(a_stream_steps, strobe && !result.last, strobe && result.record_valid && result.next_position == $past(result.next_position) + 32'd1 && result.lost_count == $past(result.lost_count), "read stream broken")

endmodule

bind lossy_event_ring_reader lerr_checker u_lerr_checker (
  .clk   (clk),
  .rst   (rst),
  .strobe(strobe),
  .result(result)
);

[verif/lerr_trace_checker.sv]
`timescale 1ns / 1ps

module lerr_trace_checker import lerr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         busy,
  input  lerr_item_t   item,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic         cfg_data,
  input  logic         strobe,
  input  lerr_result_t result,
  output int           outstanding,
  output int           failures
);

  lerr_rec_t    ring_copy [RING_RECORDS];
  logic [31:0]  record_count;
  logic         usable_copy;
  lerr_result_t expected_results [$];
  int           fail_count;

  assign failures = fail_count;

  task automatic predict_item(input lerr_item_t it);
    lerr_result_t r;
    logic [31:0]  gap;
    logic [31:0]  avail;
    logic [31:0]  lost;
    logic [31:0]  first_pos;
    logic [31:0]  pos;
    int unsigned  lim;
    int unsigned  count;
    int unsigned  k;
    if (it.op == OP_WRITE) begin
      ring_copy[record_count[RING_AW-1:0]] = '{ticks: it.in_ticks, seq: it.in_seq,
        kind: it.in_kind, context_w: it.in_context, value: it.in_value,
        previous: it.in_previous};
      record_count = record_count + 32'd1;
      return;
    end
    lim = (it.max_count > MAX_PER_READ) ? MAX_PER_READ : it.max_count;
    avail = '0;
    lost = '0;
    if (usable_copy) begin
      gap = record_count - it.reader_position;
      // reader fell behind (or claims to be ahead): whole ring readable
      if (gap > 32'(RING_RECORDS)) begin
        lost = gap - 32'(RING_RECORDS);
        avail = 32'(RING_RECORDS);
      end else begin
        avail = gap;
      end
    end
    count = (avail < lim) ? avail : lim;
    r = '0;
    r.lost_count = lost;
    if (count == 0) begin
      r.next_position = it.reader_position;
      r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    first_pos = record_count - avail;
    for (k = 0; k < count; k++) begin
      pos = first_pos + k;
      r.out_ticks     = ring_copy[pos[RING_AW-1:0]].ticks;
      r.out_seq       = ring_copy[pos[RING_AW-1:0]].seq;
      r.out_kind      = ring_copy[pos[RING_AW-1:0]].kind;
      r.out_context   = ring_copy[pos[RING_AW-1:0]].context_w;
      r.out_value     = ring_copy[pos[RING_AW-1:0]].value;
      r.out_previous  = ring_copy[pos[RING_AW-1:0]].previous;
      r.record_valid  = 1'b1;
      r.next_position = pos + 32'd1;
      r.last          = (k + 1 == count);
      expected_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(input lerr_result_t got);
    lerr_result_t want;
    if (expected_results.size() == 0) begin
      $error("result with no read waiting for it: next_position %h", got.next_position);
      fail_count++;
      return;
    end
    want = expected_results.pop_front();
    check_field("out_ticks", want.out_ticks, got.out_ticks);
    check_field("out_seq", want.out_seq, got.out_seq);
    check_field("out_kind", want.out_kind, got.out_kind);
    check_field("out_context", want.out_context, got.out_context);
    check_field("out_value", want.out_value, got.out_value);
    check_field("out_previous", want.out_previous, got.out_previous);
    check_field("record_valid", want.record_valid, got.record_valid);
    check_field("lost_count", want.lost_count, got.lost_count);
    check_field("next_position", want.next_position, got.next_position);
    check_field("last", want.last, got.last);
  endtask

  // compare before predicting: a result never belongs to an item taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      record_count = '0;
      usable_copy = 1'b0;
      expected_results.delete();
    end else begin
      if (strobe) begin
        check_result(result);
      end
      if (cfg_valid && cfg_ready) begin
        usable_copy = cfg_data;
      end
      if (start && !busy) begin
        predict_item(item);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

[verif/tb_lossy_event_ring_reader.sv]
`timescale 1ns / 1ps

module tb_lossy_event_ring_reader;
  import lerr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 500;
  localparam int SETTLE_CYCLES  = 10;

  logic         clk;
  logic         rst          = 1'b1;
  logic         start        = 1'b0;
  logic         busy;
  lerr_item_t   item         = '0;
  logic         cfg_valid    = 1'b0;
  logic         cfg_ready;
  logic         cfg_data     = 1'b0;
  logic         strobe;
  lerr_result_t result;
  int           outstanding;
  int           failures;
  int           quiet_cycles = 0;
  logic [31:0]  writes_sent  = '0;
  logic         usable_now   = 1'b0;
  bit           idle_allowed = 1'b1;

  lossy_event_ring_reader u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .result    (result)
  );

  lerr_trace_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .result      (result),
    .outstanding (outstanding),
    .failures    (failures)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // no transfer of any kind for too long means the block hung
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic lerr_item_t random_item();
    lerr_item_t it;
    it.op              = 1'($urandom_range(0, 1));
    it.in_ticks        = $urandom;
    it.in_seq          = $urandom;
    it.in_kind         = $urandom;
    it.in_context      = $urandom;
    it.in_value        = $urandom;
    it.in_previous     = $urandom;
    it.reader_position = $urandom;
    it.max_count       = 7'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic lerr_item_t write_item(input logic [31:0] w_ticks, w_seq, w_kind,
                                            w_context, w_value, w_previous);
    lerr_item_t it;
    it             = random_item();
    it.op          = OP_WRITE;
    it.in_ticks    = w_ticks;
    it.in_seq      = w_seq;
    it.in_kind     = w_kind;
    it.in_context  = w_context;
    it.in_value    = w_value;
    it.in_previous = w_previous;
    return it;
  endfunction

  function automatic lerr_item_t read_item(input logic [31:0] cursor, input logic [6:0] most);
    lerr_item_t it;
    it                 = random_item();
    it.op              = OP_READ;
    it.reader_position = cursor;
    it.max_count       = most;
    return it;
  endfunction

  // start stays high after the transfer; callers lower it only when they pause
  task automatic send_item(input lerr_item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    if (it.op == OP_WRITE) begin
      writes_sent = writes_sent + 32'd1;
    end
  endtask

  task automatic maybe_idle();
    if (idle_allowed && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_ring_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // trailing writes return nothing; give them time to leave the queue
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_usable(input logic enable);
    cfg_valid <= 1'b1;
    cfg_data  <= enable;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    usable_now = enable;
  endtask

  initial begin
    int          n;
    int          pick;
    int          write_pct;
    logic [31:0] cursor;
    logic [6:0]  most;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ring not usable: reads come back empty with no loss
    set_usable(1'b0);
    send_item(read_item(32'd0, 7'd64));
    send_item(read_item(32'hFFFF_FFFF, 7'd127));
    send_item(write_item('1, '1, '1, '1, '1, '1));
    send_item(write_item('0, '0, '0, '0, '0, '0));
    send_item(write_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                         32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    wait_ring_idle();
    set_usable(1'b1);

    send_item(read_item(32'd0, 7'd0));
    send_item(read_item(32'd3, 7'd8));
    send_item(read_item(32'd0, 7'd127));
    send_item(read_item(32'd1, 7'd1));
    // cursor ahead of the writer, zero maximum: empty but with loss
    send_item(read_item(32'd8, 7'd0));
    send_item(read_item(32'h8000_0000, 7'd0));
    repeat (6) begin
      send_item(write_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    end
    send_item(read_item(32'd0, 7'd64));
    send_item(read_item(32'd9, 7'd1));
    send_item(read_item(32'd4, 7'd3));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      idle_allowed = !(n >= 100 && n < 200);
      if (n == 150 || n == 250 || n == 300) begin
        wait_ring_idle();
      end
      if (n == 250) begin
        set_usable(1'b0);
      end
      if (n == 300) begin
        set_usable(1'b1);
      end
      maybe_idle();
      // fill past the ring size first so reads see overwrites and loss
      write_pct = (writes_sent < RING_RECORDS + 32) ? 80 : 45;
      if ($urandom_range(0, 99) < write_pct) begin
        send_item(write_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          cursor = writes_sent - $urandom_range(0, 320);
        end else if (pick < 85) begin
          cursor = $urandom;
        end else begin
          cursor = writes_sent + $urandom_range(1, 8);
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          most = 7'($urandom_range(1, 16));
        end else if (pick < 85) begin
          most = 7'($urandom_range(0, MAX_PER_READ));
        end else begin
          most = 7'($urandom_range(0, 127));
        end
        // a ring not yet full must not be read before its first record
        if (usable_now && most != 0 && writes_sent < RING_RECORDS &&
            writes_sent - cursor > writes_sent) begin
          cursor = writes_sent - $urandom_range(0, writes_sent);
        end
        send_item(read_item(cursor, most));
      end
    end

    wait_ring_idle();
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
